FILE: sv/pkmer_pkg.sv
package pkmer_pkg;

  // Bytes at or above this value carry no packed digits.
  localparam logic [7:0] PACK_LIMIT = 8'd216;

  localparam int MAX_K = 32;
  localparam int KW = 6;
  localparam int WIN_W = 2 * MAX_K;

  localparam logic [KW-1:0] K_RESET = 6'd25;
  localparam logic [KW-1:0] RUN_SAT = 6'd32;

  // Digit codes inside a packed byte.
  localparam logic [2:0] DIGIT_N   = 3'd4;
  localparam logic [2:0] DIGIT_END = 3'd5;

  typedef struct packed {
    logic [2:0] d0;
    logic [2:0] d1;
    logic [2:0] d2;
  } digits_t;

  typedef struct packed {
    logic [WIN_W-1:0] kmer_value;
    logic             has_kmer;
    logic             clean;
    logic             read_end;
    logic             run_last;
  } result_t;

  // Splits a byte below PACK_LIMIT into its three base-6 digits.
  function automatic digits_t split_byte(input logic [7:0] b);
    digits_t    d;
    logic [7:0] prod;
    logic [7:0] rem;
    logic [7:0] low;
    begin
      if (b >= 8'd180) begin
        d.d0 = 3'd5;
      end else if (b >= 8'd144) begin
        d.d0 = 3'd4;
      end else if (b >= 8'd108) begin
        d.d0 = 3'd3;
      end else if (b >= 8'd72) begin
        d.d0 = 3'd2;
      end else if (b >= 8'd36) begin
        d.d0 = 3'd1;
      end else begin
        d.d0 = 3'd0;
      end
      prod = {5'd0, d.d0} * 8'd36;
      rem = b - prod;
      if (rem >= 8'd30) begin
        d.d1 = 3'd5;
      end else if (rem >= 8'd24) begin
        d.d1 = 3'd4;
      end else if (rem >= 8'd18) begin
        d.d1 = 3'd3;
      end else if (rem >= 8'd12) begin
        d.d1 = 3'd2;
      end else if (rem >= 8'd6) begin
        d.d1 = 3'd1;
      end else begin
        d.d1 = 3'd0;
      end
      low = rem - ({5'd0, d.d1} * 8'd6);
      d.d2 = low[2:0];
      return d;
    end
  endfunction

endpackage

FILE: sv/packed_read_kmer_extractor.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    packed_byte
// result    out        out_valid / out_stall  kmer_value, has_kmer, clean, read_end, run_last
// config    in         cfg_valid / cfg_ready  kmer_length
//
// A byte gives 0 to 3 results; the single result port passes one result a cycle
// while out_stall is low. An input request is registered in the input register,
// and its results are registered in the result queue shown on the result port.
// Reset (rst, synchronous) restores k = 25 and clears the window, counters and queue.
// An input request is held in the input register while results of the previous byte drain.
// A stalled result holds its payload; the input register takes one more request behind
// it and then stalls the input.
module packed_read_kmer_extractor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      packed_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pkmer_pkg::WIN_W-1:0]     kmer_value,
  output logic                            has_kmer,
  output logic                            clean,
  output logic                            read_end,
  output logic                            run_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pkmer_pkg::KW-1:0]        kmer_length
);

  // Configuration register holding k as written.
  logic [pkmer_pkg::KW-1:0] k_length;

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;

  // Per-read state.
  logic [pkmer_pkg::WIN_W-1:0] window;
  logic [pkmer_pkg::KW-1:0]    clean_run;
  logic [pkmer_pkg::KW-1:0]    bases_in_read;

  // Result queue: entry 0 is the head shown on the result port.
  pkmer_pkg::result_t res_q [3];
  logic [1:0]         cnt;

  logic in_take;
  logic out_take;
  logic load;

  // Combinational single pass over the three digits.
  logic [pkmer_pkg::KW-1:0]    k_eff;
  logic [pkmer_pkg::WIN_W-1:0] k_mask;
  pkmer_pkg::digits_t          dig;
  logic [2:0]                  dv [3];
  pkmer_pkg::result_t          res_next [3];
  logic [1:0]                  n_next;
  logic [pkmer_pkg::WIN_W-1:0] window_next;
  logic [pkmer_pkg::KW-1:0]    clean_run_next;
  logic [pkmer_pkg::KW-1:0]    bases_next;
  logic                        prev_result;
  logic                        done;

  assign cfg_ready = 1'b1;

  // A new byte may move into the queue once the queue is empty or its last
  // entry leaves in this cycle.
  assign out_valid = (cnt != 2'd0);
  assign out_take  = out_valid && !out_stall;
  assign load      = in_full && ((cnt == 2'd0) || ((cnt == 2'd1) && out_take));
  assign in_stall  = in_full && !load;
  assign in_take   = in_valid && !in_stall;

  assign kmer_value = res_q[0].kmer_value;
  assign has_kmer   = res_q[0].has_kmer;
  assign clean      = res_q[0].clean;
  assign read_end   = res_q[0].read_end;
  assign run_last   = res_q[0].run_last;

  // Effective k: zero acts as one, anything above the window size saturates.
  always_comb begin
    if (k_length == '0) begin
      k_eff = pkmer_pkg::KW'(1);
    end else if (k_length > pkmer_pkg::KW'(pkmer_pkg::MAX_K)) begin
      k_eff = pkmer_pkg::KW'(pkmer_pkg::MAX_K);
    end else begin
      k_eff = k_length;
    end
    k_mask = {pkmer_pkg::WIN_W{1'b1}} >> (7'(pkmer_pkg::WIN_W) - {k_eff, 1'b0});
  end

  assign dig   = pkmer_pkg::split_byte(in_byte);
  assign dv[0] = dig.d0;
  assign dv[1] = dig.d1;
  assign dv[2] = dig.d2;

  // Walk the three digits in order. An end digit closes the read and stops
  // the walk; it either flags the preceding result of this byte or adds a
  // marker result.
  always_comb begin
    window_next    = window;
    clean_run_next = clean_run;
    bases_next     = bases_in_read;
    n_next         = 2'd0;
    prev_result    = 1'b0;
    done           = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res_next[i] = '0;
    end
    if (in_byte >= pkmer_pkg::PACK_LIMIT) begin
      window_next    = '0;
      clean_run_next = '0;
      bases_next     = '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (!done) begin
          if (dv[i] == pkmer_pkg::DIGIT_END) begin
            if (prev_result) begin
              res_next[n_next - 2'd1].read_end = 1'b1;
            end else begin
              res_next[n_next].read_end = 1'b1;
              n_next = n_next + 2'd1;
            end
            window_next    = '0;
            clean_run_next = '0;
            bases_next     = '0;
            done           = 1'b1;
          end else begin
            if (dv[i] == pkmer_pkg::DIGIT_N) begin
              clean_run_next = '0;
            end else begin
              window_next = {window_next[pkmer_pkg::WIN_W-3:0], dv[i][1:0]};
              if (clean_run_next < pkmer_pkg::RUN_SAT) begin
                clean_run_next = clean_run_next + 1'b1;
              end
            end
            if (bases_next < pkmer_pkg::RUN_SAT) begin
              bases_next = bases_next + 1'b1;
            end
            if (bases_next >= k_eff) begin
              res_next[n_next].has_kmer = 1'b1;
              if (clean_run_next >= k_eff) begin
                res_next[n_next].clean      = 1'b1;
                res_next[n_next].kmer_value = window_next & k_mask;
              end else begin
                res_next[n_next].kmer_value = {pkmer_pkg::WIN_W{1'b1}};
              end
              n_next      = n_next + 2'd1;
              prev_result = 1'b1;
            end else begin
              prev_result = 1'b0;
            end
          end
        end
      end
      if (n_next != 2'd0) begin
        res_next[n_next - 2'd1].run_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_length      <= pkmer_pkg::K_RESET;
      in_full       <= 1'b0;
      window        <= '0;
      clean_run     <= '0;
      bases_in_read <= '0;
      cnt           <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        k_length <= kmer_length;
      end
      if (in_take) begin
        in_full <= 1'b1;
      end else if (load) begin
        in_full <= 1'b0;
      end
      if (load) begin
        window        <= window_next;
        clean_run     <= clean_run_next;
        bases_in_read <= bases_next;
        cnt           <= n_next;
      end else if (out_take) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= packed_byte;
    end
    if (load) begin
      res_q[0] <= res_next[0];
      res_q[1] <= res_next[1];
      res_q[2] <= res_next[2];
    end else if (out_take) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

`ifndef SYNTHESIS
  // The head of the queue is the byte's last result exactly when it is the only one left.
  a_last_flag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_last == (cnt == 2'd1)))
    else $error("run_last does not match queue occupancy");

  // An end marker always closes a read and ends its byte.
  a_marker : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_kmer) |-> (read_end && run_last && !clean && (kmer_value == '0)))
    else $error("malformed end marker");

  // An unclean window result carries the all-ones value.
  a_unclean : assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_kmer && !clean) |-> (kmer_value == {pkmer_pkg::WIN_W{1'b1}}))
    else $error("unclean window not all ones");

  // A held input byte that cannot move on stays in the input register.
  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    (in_full && !load) |=> (in_full && $stable(in_byte)))
    else $error("input register lost a pending byte");
`endif

endmodule

FILE: tb/kmer_result_checker.sv
module kmer_result_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  packed_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [pkmer_pkg::WIN_W-1:0] kmer_value,
  input  logic                        has_kmer,
  input  logic                        clean,
  input  logic                        read_end,
  input  logic                        run_last,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [pkmer_pkg::KW-1:0]    kmer_length,
  output int                          mismatch_count,
  output int                          pending_count
);

  localparam int REPORT_LIMIT = 10;

  logic [pkmer_pkg::KW-1:0]    k_setting;
  logic [pkmer_pkg::WIN_W-1:0] base_window;
  logic [pkmer_pkg::KW-1:0]    clean_bases;
  logic [pkmer_pkg::KW-1:0]    read_digits;
  pkmer_pkg::result_t          expected_kmers[$];
  int                          errors = 0;

  // Register values outside 1..MAX_K are clamped into that range.
  function automatic int unsigned window_bases(input logic [pkmer_pkg::KW-1:0] k);
    if (k == '0) return 1;
    if (k > pkmer_pkg::MAX_K) return pkmer_pkg::MAX_K;
    return k;
  endfunction

  task automatic start_read();
    base_window = '0;
    clean_bases = '0;
    read_digits = '0;
  endtask

  task automatic predict_windows(input logic [7:0] b);
    int unsigned                 k;
    logic [2:0]                  digit [3];
    logic [pkmer_pkg::WIN_W-1:0] mask;
    pkmer_pkg::result_t          hits [3];
    int                          n;
    bit                          prev_hit;
    bit                          closed;
    k = window_bases(k_setting);
    mask = {pkmer_pkg::WIN_W{1'b1}} >> (pkmer_pkg::WIN_W - 2 * k);
    n = 0;
    prev_hit = 1'b0;
    closed = 1'b0;
    if (b >= pkmer_pkg::PACK_LIMIT) begin
      start_read();
    end else begin
      digit[0] = 3'(b / 36);
      digit[1] = 3'((b / 6) % 6);
      digit[2] = 3'(b % 6);
      for (int i = 0; i < 3; i++) begin
        if (!closed && digit[i] == pkmer_pkg::DIGIT_END) begin
          // The end digit tags a result made just before it from this byte,
          // or else gets a marker result of its own.
          if (prev_hit) begin
            hits[n - 1].read_end = 1'b1;
          end else begin
            hits[n] = '0;
            hits[n].read_end = 1'b1;
            n++;
          end
          start_read();
          closed = 1'b1;
        end else if (!closed) begin
          if (digit[i] == pkmer_pkg::DIGIT_N) begin
            clean_bases = '0;
          end else begin
            base_window = {base_window[pkmer_pkg::WIN_W-3:0], digit[i][1:0]};
            if (clean_bases < pkmer_pkg::RUN_SAT) clean_bases++;
          end
          if (read_digits < pkmer_pkg::RUN_SAT) read_digits++;
          prev_hit = (read_digits >= k);
          if (prev_hit) begin
            hits[n].has_kmer = 1'b1;
            hits[n].clean = (clean_bases >= k);
            hits[n].kmer_value = hits[n].clean ? (base_window & mask) : '1;
            hits[n].read_end = 1'b0;
            hits[n].run_last = 1'b0;
            n++;
          end
        end
      end
      if (n > 0) hits[n - 1].run_last = 1'b1;
      for (int i = 0; i < n; i++) expected_kmers.push_back(hits[i]);
    end
  endtask

  always @(posedge clk) begin : watch
    pkmer_pkg::result_t seen;
    pkmer_pkg::result_t want;
    if (rst) begin
      k_setting = pkmer_pkg::K_RESET;
      start_read();
      expected_kmers.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.kmer_value = kmer_value;
        seen.has_kmer = has_kmer;
        seen.clean = clean;
        seen.read_end = read_end;
        seen.run_last = run_last;
        if (expected_kmers.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected result: value=%h has_kmer=%b clean=%b read_end=%b run_last=%b",
                     seen.kmer_value, seen.has_kmer, seen.clean, seen.read_end, seen.run_last);
        end else begin
          want = expected_kmers.pop_front();
          if (seen.kmer_value !== want.kmer_value || seen.has_kmer !== want.has_kmer ||
              seen.clean !== want.clean || seen.read_end !== want.read_end ||
              seen.run_last !== want.run_last) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected value=%h has_kmer=%b clean=%b read_end=%b run_last=%b",
                       want.kmer_value, want.has_kmer, want.clean, want.read_end,
                       want.run_last);
              $display("  actual   value=%h has_kmer=%b clean=%b read_end=%b run_last=%b",
                       seen.kmer_value, seen.has_kmer, seen.clean, seen.read_end,
                       seen.run_last);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) k_setting = kmer_length;
      if (in_valid && !in_stall) predict_windows(packed_byte);
    end
    mismatch_count <= errors;
    pending_count <= expected_kmers.size();
  end

endmodule

FILE: tb/tb_packed_read_kmer_extractor.sv
module tb_packed_read_kmer_extractor;

  // The run is ended by the cycle counter if the block ever hangs. The limit is
  // far above the slowest correct run, including the long receiver hold-off.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles left after the last expected result before the block counts as
  // idle. Bytes that give no result may still be in flight at that point.
  localparam int DRAIN_CYCLES = 8;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES = 120;
  // Input bytes sent in each random phase.
  localparam int PHASE_BYTES = 44;

  // Base codes; the N and end-of-read codes come from the package.
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [7:0]                  packed_byte;
  logic                        out_valid;
  logic                        out_stall;
  logic [pkmer_pkg::WIN_W-1:0] kmer_value;
  logic                        has_kmer;
  logic                        clean;
  logic                        read_end;
  logic                        run_last;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [pkmer_pkg::KW-1:0]    kmer_length;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  // Idling rates of the two sides, in percent of cycles.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // The stimulus asks for a long hold-off by raising the first counter; the
  // receiver process answers by raising the second once it has held off.
  int hold_requests = 0;
  int holds_done = 0;

  packed_read_kmer_extractor DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .packed_byte(packed_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kmer_value (kmer_value),
    .has_kmer   (has_kmer),
    .clean      (clean),
    .read_end   (read_end),
    .run_last   (run_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .kmer_length(kmer_length)
  );

  // The checker sees every handshake of all three channels, predicts the
  // windows for each accepted byte and compares each accepted result.
  kmer_result_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .packed_byte   (packed_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kmer_value    (kmer_value),
    .has_kmer      (has_kmer),
    .clean         (clean),
    .read_end      (read_end),
    .run_last      (run_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .kmer_length   (kmer_length),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("packed_read_kmer_extractor test failed");
    $finish;
  end

  // The receiver stalls at the rate of the current phase. When a hold-off is
  // asked for, it keeps stall high for a fixed count of cycles, so that the
  // block fills up and pushes back on the sender.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        holds_done++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [7:0] pack3(input logic [2:0] d0, input logic [2:0] d1,
                                       input logic [2:0] d2);
    return 8'(d0 * 36 + d1 * 6 + d2);
  endfunction

  function automatic logic [2:0] random_base();
    return 3'($urandom_range(3));
  endfunction

  // Offers one byte and returns right after the edge that accepts it. Idle
  // cycles are put in front of the request at the rate of the phase; a
  // stalled request keeps its payload until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    packed_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops the request and waits until every expected result has come, then
  // lets the block finish any byte that gives no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic write_k(input logic [pkmer_pkg::KW-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    kmer_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Sends one well-formed read: random bases with a few Ns, then the end
  // digit, packed three to a byte. The digits after the end digit in its
  // byte are random, since the block must ignore them. Reads run from zero
  // to eight bases past k, so that some of them give windows.
  task automatic send_read(input int unsigned k_eff, inout int sent);
    logic [2:0]  digs[$];
    int unsigned len;
    logic [7:0]  b;
    len = $urandom_range(k_eff + 8);
    for (int i = 0; i < len; i++)
      digs.push_back(($urandom_range(99) < 6) ? pkmer_pkg::DIGIT_N : random_base());
    digs.push_back(pkmer_pkg::DIGIT_END);
    while (digs.size() % 3 != 0) digs.push_back(3'($urandom_range(5)));
    while (digs.size() > 0) begin
      b = pack3(digs[0], digs[1], digs[2]);
      repeat (3) void'(digs.pop_front());
      send_byte(b);
      sent++;
    end
  endtask

  // One random phase: a register setting, the idling rates of both sides,
  // and optionally the long receiver hold-off or a sender pause halfway.
  // Most bytes belong to well-formed reads; about one pick in eight sends a
  // random byte, which may break a read or clear it with a byte above the range.
  task automatic run_phase(input logic [pkmer_pkg::KW-1:0] k, input int idle,
                           input int stall, input bit long_hold, input bit mid_pause);
    int          sent;
    int unsigned k_eff;
    write_k(k);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    k_eff = (k == '0) ? 1 : ((k > pkmer_pkg::MAX_K) ? pkmer_pkg::MAX_K : k);
    if (long_hold) hold_requests++;
    sent = 0;
    while (sent < PHASE_BYTES) begin
      if (mid_pause && sent >= PHASE_BYTES / 2) begin
        settle();
        mid_pause = 1'b0;
      end
      if ($urandom_range(99) < 12) begin
        send_byte(8'($urandom_range(255)));
        sent++;
      end else begin
        send_read(k_eff, sent);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    packed_byte <= '0;
    cfg_valid <= 1'b0;
    kmer_length <= pkmer_pkg::K_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. With k = 1 every base or N gives a window, so one byte
    // can give three results.
    write_k(6'd1);
    send_byte(pack3(BASE_A, BASE_A, BASE_A));
    send_byte(pack3(BASE_T, BASE_T, BASE_T));
    // N digits give unclean windows of all ones and reset the clean count.
    send_byte(pack3(pkmer_pkg::DIGIT_N, BASE_A, pkmer_pkg::DIGIT_N));
    // An end digit right after a window tags that window as the read's last.
    send_byte(pack3(BASE_A, BASE_A, pkmer_pkg::DIGIT_END));
    // An end digit with no window before it in the byte gives a marker.
    send_byte(pack3(pkmer_pkg::DIGIT_END, BASE_A, BASE_A));
    send_byte(pack3(pkmer_pkg::DIGIT_END, pkmer_pkg::DIGIT_END, pkmer_pkg::DIGIT_END));
    // The digit after the end digit must be ignored.
    send_byte(pack3(BASE_G, pkmer_pkg::DIGIT_END, BASE_C));
    // Bytes above the packed range clear the read and give nothing.
    send_byte(pkmer_pkg::PACK_LIMIT);
    send_byte(8'hFF);

    // A register value of zero acts as one.
    write_k(6'd0);
    send_byte(pack3(BASE_A, pkmer_pkg::DIGIT_N, BASE_T));
    send_byte(pack3(BASE_A, pkmer_pkg::DIGIT_END, BASE_T));

    // The largest register value acts as MAX_K: a read of 33 bases fills the
    // whole window and runs the counters into saturation, then an N makes
    // the rest unclean and a lone end digit closes the read with a marker.
    write_k(6'd63);
    repeat (11) send_byte(pack3(random_base(), random_base(), random_base()));
    send_byte(pack3(BASE_C, pkmer_pkg::DIGIT_N, BASE_G));
    send_byte(pack3(pkmer_pkg::DIGIT_END, BASE_A, BASE_A));

    // Random phases. The first has no idling and the long hold-off, so that
    // the block fills up while the sender keeps its request up.
    run_phase(pkmer_pkg::K_RESET, 0, 0, 1'b1, 1'b0);
    run_phase(6'(pkmer_pkg::MAX_K), 71, 0, 1'b0, 1'b0);
    run_phase(6'd1, 0, 71, 1'b0, 1'b1);
    run_phase(6'($urandom_range(31, 2)), 28, 28, 1'b0, 1'b0);

    // Wait for the last results; the cycle counter bounds this wait.
    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("packed_read_kmer_extractor test passed");
    end else begin
      $display("packed_read_kmer_extractor test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pkmer_pkg.sv
sv/packed_read_kmer_extractor.sv
tb/kmer_result_checker.sv
tb/tb_packed_read_kmer_extractor.sv
